// ===== hdl/pcr_pkg.sv =====
package pcr_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int RATIO_BITS = 24;
	localparam int SEP_CONST  = ((1 << FRAC_BITS) + 50) / 100;

	localparam int ROOT_BITS  = 32;
	localparam int QUO_BITS   = 25;
	localparam int NUM_W      = 57;
	localparam int DEN_W      = 33;
	localparam int NRM_W      = 26;

	localparam int LATENCY    = 67;

	localparam logic [16:0] RESTITUTION_RESET = 17'd65536;
	localparam logic [32:0] MIN_DIST_RESET    = 33'd4295;
	localparam logic [17:0] GAIN_ONE          = 18'd65536;

	localparam logic [0:0] REG_RESTITUTION = 1'b0;
	localparam logic [0:0] REG_MIN_DIST    = 1'b1;

	typedef struct packed {
		logic [31:0] x1;
		logic [31:0] y1;
		logic [31:0] vx1;
		logic [31:0] vy1;
		logic [31:0] x2;
		logic [31:0] y2;
		logic [31:0] vx2;
		logic [31:0] vy2;
	} kin_t;

	typedef struct packed {
		kin_t        kin;
		logic [31:0] m1;
		logic [31:0] m2;
		logic [32:0] mt;
		logic [31:0] ax;
		logic [31:0] ay;
		logic        neg_x;
		logic        neg_y;
		logic [31:0] rsum;
		logic [31:0] span;
		logic        pre_ok;
	} pair_ctx_t;

	function automatic logic [51:0] sext52(input logic [31:0] v);
		return {{20{v[31]}}, v};
	endfunction

	function automatic logic [31:0] sat32(input logic [51:0] v);
		if (v[51:31] == {21{1'b0}} || v[51:31] == {21{1'b1}}) begin
			return v[31:0];
		end
		return v[51] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	endfunction

endpackage

// ===== hdl/particle_pair_collision_response.sv =====
// Pairwise disc collision response, fully pipelined.
// Each start transfer passes the front, square root, divider and back-end stages to the done strobe.
// Throughput: one pair per cycle; busy is never raised.
// Depth is set by the 32-stage square root and the 25-stage dividers.
// Reset clears the pipeline valid bits and loads the register defaults.
module particle_pair_collision_response (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic signed [31:0] first_pos_x,
	input  logic signed [31:0] first_pos_y,
	input  logic signed [31:0] first_vel_x,
	input  logic signed [31:0] first_vel_y,
	input  logic [31:0] first_mass,
	input  logic [30:0] first_radius,
	input  logic signed [31:0] second_pos_x,
	input  logic signed [31:0] second_pos_y,
	input  logic signed [31:0] second_vel_x,
	input  logic signed [31:0] second_vel_y,
	input  logic [31:0] second_mass,
	input  logic [30:0] second_radius,
	output logic signed [31:0] new_first_pos_x,
	output logic signed [31:0] new_first_pos_y,
	output logic signed [31:0] new_first_vel_x,
	output logic signed [31:0] new_first_vel_y,
	output logic signed [31:0] new_second_pos_x,
	output logic signed [31:0] new_second_pos_y,
	output logic signed [31:0] new_second_vel_x,
	output logic signed [31:0] new_second_vel_y,
	output logic        collided
);

	localparam int F    = pcr_pkg::FRAC_BITS;
	localparam int DIVS = pcr_pkg::QUO_BITS;

	logic [16:0] restitution;
	logic [32:0] min_dist_squared;

	pcr_regs u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.restitution      (restitution),
		.min_dist_squared (min_dist_squared)
	);

	assign busy = 1'b0;

	// front: differences, squares, range checks
	logic               vld_s1, vld_s2, vld_s3;
	pcr_pkg::pair_ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_c1, ctx_c3;
	logic [63:0]        sqx_s2, sqy_s2, rsq_s2, s_s3;
	logic [32:0]        dx, dy, adx, ady;
	logic [64:0]        ssum;

	always_comb begin
		dx  = {second_pos_x[31], second_pos_x} - {first_pos_x[31], first_pos_x};
		dy  = {second_pos_y[31], second_pos_y} - {first_pos_y[31], first_pos_y};
		adx = dx[32] ? 33'(-dx) : dx;
		ady = dy[32] ? 33'(-dy) : dy;
		ctx_c1.kin.x1  = first_pos_x;
		ctx_c1.kin.y1  = first_pos_y;
		ctx_c1.kin.vx1 = first_vel_x;
		ctx_c1.kin.vy1 = first_vel_y;
		ctx_c1.kin.x2  = second_pos_x;
		ctx_c1.kin.y2  = second_pos_y;
		ctx_c1.kin.vx2 = second_vel_x;
		ctx_c1.kin.vy2 = second_vel_y;
		ctx_c1.m1      = first_mass;
		ctx_c1.m2      = second_mass;
		ctx_c1.mt      = {1'b0, first_mass} + {1'b0, second_mass};
		ctx_c1.ax      = adx[31:0];
		ctx_c1.ay      = ady[31:0];
		ctx_c1.neg_x   = dx[32];
		ctx_c1.neg_y   = dy[32];
		ctx_c1.rsum    = {1'b0, first_radius} + {1'b0, second_radius};
		ctx_c1.span    = 32'd0;
		ctx_c1.pre_ok  = 1'b0;
		ssum = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		ctx_c3 = ctx_s2;
		ctx_c3.pre_ok = !ssum[64] && (ssum[63:0] < rsq_s2)
			&& (ssum >= {32'd0, min_dist_squared}) && (ssum != 65'd0);
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= ctx_c1;
		ctx_s2 <= ctx_s1;
		sqx_s2 <= ctx_s1.ax * ctx_s1.ax;
		sqy_s2 <= ctx_s1.ay * ctx_s1.ay;
		rsq_s2 <= ctx_s1.rsum * ctx_s1.rsum;
		s_s3   <= ssum[63:0];
		ctx_s3 <= ctx_c3;
	end

	// square root
	logic               root_vld;
	logic [31:0]        root;
	pcr_pkg::pair_ctx_t root_ctx, dv_ctx;

	pcr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_val   (s_s3),
		.in_ctx   (ctx_s3),
		.out_vld  (root_vld),
		.out_root (root),
		.out_ctx  (root_ctx)
	);

	always_comb begin
		dv_ctx = root_ctx;
		dv_ctx.span = root;
	end

	// normal components and mass ratios
	logic [pcr_pkg::QUO_BITS-1:0] qx, qy, qw1, qw2;

	pcr_div u_div_nx (
		.clk (clk),
		.num (pcr_pkg::NUM_W'(dv_ctx.ax) << F),
		.den ({1'b0, dv_ctx.span}),
		.quo (qx)
	);

	pcr_div u_div_ny (
		.clk (clk),
		.num (pcr_pkg::NUM_W'(dv_ctx.ay) << F),
		.den ({1'b0, dv_ctx.span}),
		.quo (qy)
	);

	pcr_div u_div_w1 (
		.clk (clk),
		.num (pcr_pkg::NUM_W'(dv_ctx.m1) << pcr_pkg::RATIO_BITS),
		.den (dv_ctx.mt),
		.quo (qw1)
	);

	pcr_div u_div_w2 (
		.clk (clk),
		.num (pcr_pkg::NUM_W'(dv_ctx.m2) << pcr_pkg::RATIO_BITS),
		.den (dv_ctx.mt),
		.quo (qw2)
	);

	logic [DIVS-1:0]    dly_vld_q;
	pcr_pkg::pair_ctx_t dly_ctx_q [DIVS];

	always_ff @(posedge clk) begin
		dly_ctx_q[0] <= dv_ctx;
		for (int i = 1; i < DIVS; i++) begin
			dly_ctx_q[i] <= dly_ctx_q[i-1];
		end
	end

	// back end: impulse and separation
	pcr_pkg::pair_ctx_t dctx;
	logic [32:0] cdiff;

	assign dctx  = dly_ctx_q[DIVS-1];
	assign cdiff = {1'b0, dctx.rsum} - {1'b0, dctx.span};

	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic pre_ok_s4, pre_ok_s5;
	logic hit_s6, hit_s7, hit_s8, hit_s9;
	pcr_pkg::kin_t kin_s4, kin_s5, kin_s6, kin_s7, kin_s8, kin_s9;
	logic signed [pcr_pkg::NRM_W-1:0] nx_s4, ny_s4, nx_s5, ny_s5, nx_s6, ny_s6;
	logic signed [pcr_pkg::NRM_W-1:0] nx_s7, ny_s7, nx_s8, ny_s8;
	logic [pcr_pkg::QUO_BITS-1:0] w1_s4, w2_s4, w1_s5, w2_s5, w1_s6, w2_s6, w1_s7, w2_s7;
	logic signed [32:0] rvx_s4, rvy_s4;
	logic signed [33:0] c_s4;
	logic signed [58:0] prx_s5, pry_s5;
	logic signed [59:0] ncx_s5, ncy_s5;
	logic signed [59:0] psum, pshift, ncx_sh, ncy_sh;
	logic [59:0]        aneg;
	logic [39:0]        a_s6, j_s7, k1_s8, k2_s8;
	logic signed [47:0] ofsx_s6, ofsy_s6, ofsx_s7, ofsy_s7, ofsx_s8, ofsy_s8;
	logic signed [47:0] ofsx_s9, ofsy_s9;
	logic [17:0]        gain;
	logic [57:0]        jprod;
	logic [64:0]        kprod1, kprod2;
	logic signed [66:0] nk1x_s9, nk1y_s9, nk2x_s9, nk2y_s9;

	always_comb begin
		psum   = 60'(prx_s5) + 60'(pry_s5);
		pshift = psum >>> F;
		aneg   = 60'(-pshift);
		ncx_sh = ncx_s5 >>> F;
		ncy_sh = ncy_s5 >>> F;
		gain   = pcr_pkg::GAIN_ONE + {1'b0, restitution};
		jprod  = 58'(a_s6) * 58'(gain);
		kprod1 = 65'(j_s7) * 65'(w2_s7);
		kprod2 = 65'(j_s7) * 65'(w1_s7);
	end

	always_ff @(posedge clk) begin
		// s4: signed normal, masked ratios, relative velocity, push distance
		nx_s4     <= dctx.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		ny_s4     <= dctx.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		w1_s4     <= (dctx.mt == 33'd0) ? '0 : qw1;
		w2_s4     <= (dctx.mt == 33'd0) ? '0 : qw2;
		rvx_s4    <= $signed({dctx.kin.vx1[31], dctx.kin.vx1})
			- $signed({dctx.kin.vx2[31], dctx.kin.vx2});
		rvy_s4    <= $signed({dctx.kin.vy1[31], dctx.kin.vy1})
			- $signed({dctx.kin.vy2[31], dctx.kin.vy2});
		c_s4      <= $signed({2'b00, cdiff[32:1]}) + 34'(pcr_pkg::SEP_CONST);
		kin_s4    <= dctx.kin;
		pre_ok_s4 <= dctx.pre_ok;
		// s5
		prx_s5    <= rvx_s4 * nx_s4;
		pry_s5    <= rvy_s4 * ny_s4;
		ncx_s5    <= nx_s4 * c_s4;
		ncy_s5    <= ny_s4 * c_s4;
		nx_s5     <= nx_s4;
		ny_s5     <= ny_s4;
		w1_s5     <= w1_s4;
		w2_s5     <= w2_s4;
		kin_s5    <= kin_s4;
		pre_ok_s5 <= pre_ok_s4;
		// s6: approach test
		a_s6      <= aneg[39:0];
		hit_s6    <= pre_ok_s5 && psum[59];
		ofsx_s6   <= ncx_sh[47:0];
		ofsy_s6   <= ncy_sh[47:0];
		nx_s6     <= nx_s5;
		ny_s6     <= ny_s5;
		w1_s6     <= w1_s5;
		w2_s6     <= w2_s5;
		kin_s6    <= kin_s5;
		// s7: impulse magnitude
		j_s7      <= jprod[55:16];
		hit_s7    <= hit_s6;
		ofsx_s7   <= ofsx_s6;
		ofsy_s7   <= ofsy_s6;
		nx_s7     <= nx_s6;
		ny_s7     <= ny_s6;
		w1_s7     <= w1_s6;
		w2_s7     <= w2_s6;
		kin_s7    <= kin_s6;
		// s8: per-particle share
		k1_s8     <= kprod1[pcr_pkg::RATIO_BITS +: 40];
		k2_s8     <= kprod2[pcr_pkg::RATIO_BITS +: 40];
		hit_s8    <= hit_s7;
		ofsx_s8   <= ofsx_s7;
		ofsy_s8   <= ofsy_s7;
		nx_s8     <= nx_s7;
		ny_s8     <= ny_s7;
		kin_s8    <= kin_s7;
		// s9: velocity deltas
		nk1x_s9   <= nx_s8 * $signed({1'b0, k1_s8});
		nk1y_s9   <= ny_s8 * $signed({1'b0, k1_s8});
		nk2x_s9   <= nx_s8 * $signed({1'b0, k2_s8});
		nk2y_s9   <= ny_s8 * $signed({1'b0, k2_s8});
		hit_s9    <= hit_s8;
		ofsx_s9   <= ofsx_s8;
		ofsy_s9   <= ofsy_s8;
		kin_s9    <= kin_s8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			dly_vld_q <= '0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			done      <= 1'b0;
		end else begin
			vld_s1    <= start && !busy;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			dly_vld_q <= {dly_vld_q[DIVS-2:0], root_vld};
			vld_s4    <= dly_vld_q[DIVS-1];
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_s8    <= vld_s7;
			vld_s9    <= vld_s8;
			done      <= vld_s9;
		end
	end

	// output stage: apply, saturate, select
	logic signed [66:0] d1x, d1y, d2x, d2y;
	logic [51:0] o_x1, o_y1, o_vx1, o_vy1, o_x2, o_y2, o_vx2, o_vy2;

	always_comb begin
		d1x   = nk1x_s9 >>> F;
		d1y   = nk1y_s9 >>> F;
		d2x   = nk2x_s9 >>> F;
		d2y   = nk2y_s9 >>> F;
		o_x1  = pcr_pkg::sext52(kin_s9.x1) - 52'(ofsx_s9);
		o_y1  = pcr_pkg::sext52(kin_s9.y1) - 52'(ofsy_s9);
		o_x2  = pcr_pkg::sext52(kin_s9.x2) + 52'(ofsx_s9);
		o_y2  = pcr_pkg::sext52(kin_s9.y2) + 52'(ofsy_s9);
		o_vx1 = pcr_pkg::sext52(kin_s9.vx1) + d1x[51:0];
		o_vy1 = pcr_pkg::sext52(kin_s9.vy1) + d1y[51:0];
		o_vx2 = pcr_pkg::sext52(kin_s9.vx2) - d2x[51:0];
		o_vy2 = pcr_pkg::sext52(kin_s9.vy2) - d2y[51:0];
	end

	always_ff @(posedge clk) begin
		if (hit_s9) begin
			new_first_pos_x  <= pcr_pkg::sat32(o_x1);
			new_first_pos_y  <= pcr_pkg::sat32(o_y1);
			new_first_vel_x  <= pcr_pkg::sat32(o_vx1);
			new_first_vel_y  <= pcr_pkg::sat32(o_vy1);
			new_second_pos_x <= pcr_pkg::sat32(o_x2);
			new_second_pos_y <= pcr_pkg::sat32(o_y2);
			new_second_vel_x <= pcr_pkg::sat32(o_vx2);
			new_second_vel_y <= pcr_pkg::sat32(o_vy2);
		end else begin
			new_first_pos_x  <= kin_s9.x1;
			new_first_pos_y  <= kin_s9.y1;
			new_first_vel_x  <= kin_s9.vx1;
			new_first_vel_y  <= kin_s9.vy1;
			new_second_pos_x <= kin_s9.x2;
			new_second_pos_y <= kin_s9.y2;
			new_second_vel_x <= kin_s9.vx2;
			new_second_vel_y <= kin_s9.vy2;
		end
		collided <= hit_s9;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(pcr_pkg::LATENCY) done)
		else $error("result strobe missing");

	a_no_hit_without_contact: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && !pre_ok_s5 |=> !hit_s6)
		else $error("impulse without contact");

	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		done && !collided |-> new_first_vel_x == $past(first_vel_x, pcr_pkg::LATENCY)
			&& new_second_pos_y == $past(second_pos_y, pcr_pkg::LATENCY))
		else $error("pass-through data corrupted");

endmodule

// ===== hdl/pcr_regs.sv =====
module pcr_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	output logic [16:0] restitution,
	output logic [32:0] min_dist_squared
);

	logic [16:0] restitution_q;
	logic [32:0] min_dist_q;
	logic        wr;

	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign restitution = restitution_q;
	assign min_dist_squared = min_dist_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= pcr_pkg::RESTITUTION_RESET;
			min_dist_q    <= pcr_pkg::MIN_DIST_RESET;
		end else if (wr) begin
			case (paddr[3])
				pcr_pkg::REG_RESTITUTION: restitution_q <= pwdata[16:0];
				pcr_pkg::REG_MIN_DIST:    min_dist_q    <= pwdata[32:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			pcr_pkg::REG_RESTITUTION: prdata = {47'd0, restitution_q};
			pcr_pkg::REG_MIN_DIST:    prdata = {31'd0, min_dist_q};
			default:                  prdata = 64'd0;
		endcase
	end

endmodule

// ===== hdl/pcr_isqrt.sv =====
module pcr_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [63:0]        in_val,
	input  pcr_pkg::pair_ctx_t in_ctx,
	output logic               out_vld,
	output logic [31:0]        out_root,
	output pcr_pkg::pair_ctx_t out_ctx
);

	localparam int STAGES = pcr_pkg::ROOT_BITS;

	logic [STAGES-1:0]  vld_q;
	logic [63:0]        rem_q  [STAGES];
	logic [31:0]        root_q [STAGES];
	pcr_pkg::pair_ctx_t ctx_q  [STAGES];

	logic [63:0]        rem_in   [STAGES];
	logic [31:0]        root_in  [STAGES];
	pcr_pkg::pair_ctx_t ctx_in   [STAGES];
	logic [65:0]        trial    [STAGES];
	logic [STAGES-1:0]  take;

	// one root bit per stage, msb first
	always_comb begin
		for (int g = 0; g < STAGES; g++) begin
			if (g == 0) begin
				rem_in[g]  = in_val;
				root_in[g] = 32'd0;
				ctx_in[g]  = in_ctx;
			end else begin
				rem_in[g]  = rem_q[g-1];
				root_in[g] = root_q[g-1];
				ctx_in[g]  = ctx_q[g-1];
			end
			trial[g] = ({34'd0, root_in[g]} << (STAGES - g))
				| (66'd1 << (2 * (STAGES - 1 - g)));
			take[g] = {2'b00, rem_in[g]} >= trial[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[STAGES-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < STAGES; g++) begin
			if (take[g]) begin
				rem_q[g]  <= rem_in[g] - trial[g][63:0];
				root_q[g] <= root_in[g] | (32'd1 << (STAGES - 1 - g));
			end else begin
				rem_q[g]  <= rem_in[g];
				root_q[g] <= root_in[g];
			end
			ctx_q[g] <= ctx_in[g];
		end
	end

	assign out_vld  = vld_q[STAGES-1];
	assign out_root = root_q[STAGES-1];
	assign out_ctx  = ctx_q[STAGES-1];

endmodule

// ===== hdl/pcr_div.sv =====
module pcr_div (
	input  logic                         clk,
	input  logic [pcr_pkg::NUM_W-1:0]    num,
	input  logic [pcr_pkg::DEN_W-1:0]    den,
	output logic [pcr_pkg::QUO_BITS-1:0] quo
);

	localparam int STAGES = pcr_pkg::QUO_BITS;
	localparam int REM_W  = pcr_pkg::NUM_W + 1;

	logic [REM_W-1:0]         rem_q [STAGES];
	logic [pcr_pkg::DEN_W-1:0] den_q [STAGES];
	logic [STAGES-1:0]        quo_q [STAGES];

	logic [REM_W-1:0]          rem_in [STAGES];
	logic [pcr_pkg::DEN_W-1:0] den_in [STAGES];
	logic [STAGES-1:0]         quo_in [STAGES];
	logic [REM_W-1:0]          sub    [STAGES];
	logic [STAGES-1:0]         take;

	// restoring division, one quotient bit per stage
	always_comb begin
		for (int g = 0; g < STAGES; g++) begin
			if (g == 0) begin
				rem_in[g] = {1'b0, num};
				den_in[g] = den;
				quo_in[g] = '0;
			end else begin
				rem_in[g] = rem_q[g-1];
				den_in[g] = den_q[g-1];
				quo_in[g] = quo_q[g-1];
			end
			sub[g]  = REM_W'(den_in[g]) << (STAGES - 1 - g);
			take[g] = rem_in[g] >= sub[g];
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < STAGES; g++) begin
			rem_q[g] <= take[g] ? rem_in[g] - sub[g] : rem_in[g];
			quo_q[g] <= take[g] ? quo_in[g] | (STAGES'(1) << (STAGES - 1 - g)) : quo_in[g];
			den_q[g] <= den_in[g];
		end
	end

	assign quo = quo_q[STAGES-1];

endmodule
